### hw/rtl/bae_pkg.sv
// Shared types and constants for the binary arithmetic encoder.
// Used by bae_div, bae_store and binary_arithmetic_encoder; no dependencies.
package bae_pkg;

  localparam int unsigned PRECISION_BITS_DEF = 16;
  localparam int unsigned FREQ_BITS_DEF      = 16;
  localparam int unsigned PENDING_BITS_DEF   = 8;

  localparam int unsigned FREQ_FIELD_W = 16;
  localparam int unsigned MAX_RESULTS  = 36;

  localparam logic [1:0] FUNC_ENCODE  = 2'd0;
  localparam logic [1:0] FUNC_FLUSH   = 2'd1;
  localparam logic [1:0] FUNC_RESTART = 2'd2;

  typedef struct packed {
    logic [1:0]              func;
    logic                    bit_value;
    logic [FREQ_FIELD_W-1:0] freq_zero;
    logic [FREQ_FIELD_W-1:0] freq_total;
  } bae_cmd_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       pending_overflow;
  } bae_code_t;

  typedef struct packed {
    logic       push;
    logic [7:0] data;
    logic       drain;
    logic       overflow;
  } bae_store_req_t;

endpackage

### hw/rtl/bae_div.sv
// Shared multiply and restoring divide unit: quot = range * fz / ft.
// Registers the product, then produces one quotient bit per cycle. Uses bae_pkg.
module bae_div #(
  parameter int unsigned RANGE_W = 17,
  parameter int unsigned FREQ_W  = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [RANGE_W-1:0]        range_in,
  input  logic [FREQ_W-1:0]         fz,
  input  logic [FREQ_W-1:0]         ft,
  output logic                      done,
  output logic [RANGE_W+FREQ_W-1:0] quot
);
  import bae_pkg::*;

  localparam int unsigned PROD_W = RANGE_W + FREQ_W;
  localparam int unsigned CNT_W  = $clog2(PROD_W + 1);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_RUN  = 2'd2;

  logic [1:0]         phase;
  logic [CNT_W-1:0]   cnt;
  logic [RANGE_W-1:0] a;
  logic [FREQ_W-1:0]  b;
  logic [FREQ_W-1:0]  d;
  logic [PROD_W-1:0]  qp;
  logic [FREQ_W-1:0]  rem;
  logic [PROD_W-1:0]  prod;
  logic [FREQ_W:0]    rem_sh;
  logic [FREQ_W:0]    diff;
  logic               ge;

  assign prod   = a * b;
  assign rem_sh = {rem, qp[PROD_W-1]};
  assign ge     = rem_sh >= {1'b0, d};
  assign diff   = rem_sh - {1'b0, d};
  assign quot   = qp;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        PH_IDLE: begin
          if (start) phase <= PH_MUL;
        end
        PH_MUL: begin
          cnt   <= CNT_W'(PROD_W);
          phase <= PH_RUN;
        end
        PH_RUN: begin
          cnt <= cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) begin
            phase <= PH_IDLE;
            done  <= 1'b1;
          end
        end
        default: phase <= PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (phase)
      PH_IDLE: begin
        if (start) begin
          a <= range_in;
          b <= fz;
          d <= ft;
        end
      end
      PH_MUL: begin
        qp  <= prod;
        rem <= '0;
      end
      PH_RUN: begin
        qp  <= {qp[PROD_W-2:0], ge};
        rem <= ge ? diff[FREQ_W-1:0] : rem_sh[FREQ_W-1:0];
      end
      default: ;
    endcase
  end

endmodule

### hw/rtl/bae_store.sv
// Byte store for one request's code bytes and the output register that drains it.
// Tags each byte with last and the final overflow flag. Uses bae_pkg.
module bae_store (
  input  logic                    clk,
  input  logic                    rst,
  input  bae_pkg::bae_store_req_t req,
  output logic                    draining,
  output logic                    code_valid,
  input  logic                    code_stall,
  output bae_pkg::bae_code_t      code_data
);
  import bae_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_RESULTS);
  localparam int unsigned CNT_W = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] DR_IDLE = 2'd0;
  localparam logic [1:0] DR_READ = 2'd1;
  localparam logic [1:0] DR_LOAD = 2'd2;

  logic [7:0]       mem [MAX_RESULTS];
  logic [7:0]       rdata;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] rd;
  logic [1:0]       phase;
  logic             can_load;
  logic             load;
  logic             is_last;

  assign can_load = !code_valid || !code_stall;
  assign load     = (phase == DR_LOAD) && can_load;
  assign is_last  = (rd + CNT_W'(1)) == cnt;
  assign draining = phase != DR_IDLE;

  always_ff @(posedge clk) begin
    if (req.push && cnt < CNT_W'(MAX_RESULTS)) mem[cnt[IDX_W-1:0]] <= req.data;
    rdata <= mem[rd[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      rd         <= '0;
      phase      <= DR_IDLE;
      code_valid <= 1'b0;
    end else begin
      if (code_valid && !code_stall) code_valid <= 1'b0;
      case (phase)
        DR_IDLE: begin
          if (req.push && cnt < CNT_W'(MAX_RESULTS)) cnt <= cnt + CNT_W'(1);
          if (req.drain && cnt != '0) begin
            rd    <= '0;
            phase <= DR_READ;
          end
        end
        DR_READ: phase <= DR_LOAD;
        DR_LOAD: begin
          if (can_load) begin
            code_valid <= 1'b1;
            if (is_last) begin
              cnt   <= '0;
              phase <= DR_IDLE;
            end else begin
              rd    <= rd + CNT_W'(1);
              phase <= DR_READ;
            end
          end
        end
        default: phase <= DR_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code_data.out_byte         <= rdata;
      code_data.last             <= is_last;
      code_data.pending_overflow <= req.overflow;
    end
  end

endmodule

### hw/rtl/binary_arithmetic_encoder.sv
// Binary arithmetic encoder top level: interval state, renormalization sequencer.
// Encode: the multiply/divide unit scales the range, then the renormalization loop puts each
// settled code bit (S_PUT), releases pending bits one at a time (S_PEND) and applies middle-half
// scalings (S_MID, or S_RENORM for a lone one) before draining the code bytes (longer under stall).
// Flush puts the final bit, releases pending bits and packs the last byte before draining; restart acts in S_IDLE.
// One request at a time. Synchronous reset clears the interval to full range and all counts.
module binary_arithmetic_encoder #(
  parameter int unsigned PRECISION_BITS = bae_pkg::PRECISION_BITS_DEF,
  parameter int unsigned FREQ_BITS      = bae_pkg::FREQ_BITS_DEF,
  parameter int unsigned PENDING_BITS   = bae_pkg::PENDING_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  bae_pkg::bae_cmd_t  cmd_data,
  output logic               code_valid,
  input  logic               code_stall,
  output bae_pkg::bae_code_t code_data
);
  import bae_pkg::*;

  localparam int unsigned P  = PRECISION_BITS;
  localparam int unsigned RW = P + 1;
  localparam int unsigned F  = FREQ_BITS;
  localparam int unsigned QW = RW + F;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DIV    = 4'd1;
  localparam logic [3:0] S_RENORM = 4'd2;
  localparam logic [3:0] S_PUT    = 4'd3;
  localparam logic [3:0] S_PEND   = 4'd4;
  localparam logic [3:0] S_MID    = 4'd5;
  localparam logic [3:0] S_FLUSH  = 4'd6;
  localparam logic [3:0] S_FIN    = 4'd7;
  localparam logic [3:0] S_DRAIN  = 4'd8;
  localparam logic [3:0] S_WAIT   = 4'd9;

  logic [3:0]              state, state_next;
  logic [P-1:0]            low, low_next;
  logic [P-1:0]            high, high_next;
  logic [PENDING_BITS-1:0] pending, pending_next;
  logic [7:0]              buffer, buffer_next;
  logic [2:0]              bits, bits_next;
  logic                    overflow, overflow_next;
  logic                    sym, sym_next;
  logic                    is_flush, is_flush_next;
  logic                    cur_bit, cur_bit_next;

  logic                    accept;
  logic                    div_start;
  logic                    div_done;
  logic [QW-1:0]           quot;
  logic [RW-1:0]           range_w;
  logic [RW-1:0]           lim;
  logic [P-1:0]            len_cap;
  logic [P-1:0]            len;
  logic [F+FREQ_FIELD_W-1:0] fz_ext;
  logic [F+FREQ_FIELD_W-1:0] ft_ext;
  logic                    same;
  logic                    mid;
  logic                    low_q;
  logic                    emit;
  logic                    emit_bit;
  logic                    inc;
  logic                    fin_push;
  logic [7:0]              fin_byte;
  logic                    draining;
  bae_store_req_t          store_req;

  assign accept    = cmd_valid && !cmd_stall;
  assign cmd_stall = state != S_IDLE;
  assign div_start = accept && cmd_data.func == FUNC_ENCODE;

  assign fz_ext  = {{F{1'b0}}, cmd_data.freq_zero};
  assign ft_ext  = {{F{1'b0}}, cmd_data.freq_total};
  assign range_w = {1'b0, high} - {1'b0, low} + RW'(1);
  assign lim     = range_w - RW'(1);
  assign len_cap = (quot > {{F{1'b0}}, lim}) ? lim[P-1:0] : quot[P-1:0];
  assign len     = (len_cap == '0) ? P'(1) : len_cap;

  assign same  = low[P-1] == high[P-1];
  assign low_q = low[P-1:P-2] != 2'b00;
  assign mid   = low_q && (high[P-1:P-2] != 2'b11);

  assign fin_byte = (bits != 3'd0) ? (buffer >> (4'd8 - {1'b0, bits})) : buffer;

  bae_div #(
    .RANGE_W(RW),
    .FREQ_W (F)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .range_in(range_w),
    .fz      (fz_ext[F-1:0]),
    .ft      (ft_ext[F-1:0]),
    .done    (div_done),
    .quot    (quot)
  );

  always_comb begin
    state_next    = state;
    low_next      = low;
    high_next     = high;
    pending_next  = pending;
    buffer_next   = buffer;
    bits_next     = bits;
    overflow_next = overflow;
    sym_next      = sym;
    is_flush_next = is_flush;
    cur_bit_next  = cur_bit;
    emit          = 1'b0;
    emit_bit      = cur_bit;
    inc           = 1'b0;
    fin_push      = 1'b0;
    store_req     = '0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (cmd_data.func)
            FUNC_ENCODE: begin
              sym_next      = cmd_data.bit_value;
              is_flush_next = 1'b0;
              state_next    = S_DIV;
            end
            FUNC_FLUSH: begin
              is_flush_next = 1'b1;
              state_next    = S_FLUSH;
            end
            FUNC_RESTART: begin
              low_next      = '0;
              high_next     = '1;
              pending_next  = '0;
              buffer_next   = '0;
              bits_next     = '0;
              overflow_next = 1'b0;
            end
            default: ;
          endcase
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (sym) low_next = low + len;
          else     high_next = low + len - P'(1);
          state_next = S_RENORM;
        end
      end
      S_RENORM: begin
        if (same) begin
          cur_bit_next = low[P-1];
          low_next     = {low[P-2:0], 1'b0};
          high_next    = {high[P-2:0], 1'b1};
          state_next   = S_PUT;
        end else if (mid) begin
          low_next  = {~low[P-2], low[P-3:0], 1'b0};
          high_next = {~high[P-2], high[P-3:0], 1'b1};
          inc       = 1'b1;
        end else begin
          state_next = S_DRAIN;
        end
      end
      S_PUT: begin
        emit       = 1'b1;
        state_next = S_PEND;
      end
      S_PEND: begin
        if (pending != '0) begin
          pending_next = pending - PENDING_BITS'(1);
          emit         = 1'b1;
          emit_bit     = ~cur_bit;
        end else begin
          state_next = is_flush ? S_FIN : S_MID;
        end
      end
      S_MID: begin
        if (mid) begin
          low_next  = {~low[P-2], low[P-3:0], 1'b0};
          high_next = {~high[P-2], high[P-3:0], 1'b1};
          inc       = 1'b1;
        end
        state_next = S_RENORM;
      end
      S_FLUSH: begin
        cur_bit_next = low_q;
        inc          = 1'b1;
        state_next   = S_PUT;
      end
      S_FIN: begin
        buffer_next = fin_byte;
        bits_next   = '0;
        fin_push    = 1'b1;
        state_next  = S_DRAIN;
      end
      S_DRAIN: begin
        store_req.drain = 1'b1;
        state_next      = S_WAIT;
      end
      S_WAIT: begin
        if (!draining) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase

    if (inc) begin
      if (&pending) overflow_next = 1'b1;
      else          pending_next  = pending + PENDING_BITS'(1);
    end

    if (emit) begin
      buffer_next = {emit_bit, buffer[7:1]};
      bits_next   = bits + 3'd1;
      if (bits == 3'd7) begin
        store_req.push = 1'b1;
        store_req.data = buffer_next;
      end
    end

    if (fin_push) begin
      store_req.push = 1'b1;
      store_req.data = fin_byte;
    end

    store_req.overflow = overflow;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      low      <= '0;
      high     <= '1;
      pending  <= '0;
      buffer   <= '0;
      bits     <= '0;
      overflow <= 1'b0;
    end else begin
      state    <= state_next;
      low      <= low_next;
      high     <= high_next;
      pending  <= pending_next;
      buffer   <= buffer_next;
      bits     <= bits_next;
      overflow <= overflow_next;
    end
  end

  always_ff @(posedge clk) begin
    sym      <= sym_next;
    is_flush <= is_flush_next;
    cur_bit  <= cur_bit_next;
  end

  bae_store u_store (
    .clk       (clk),
    .rst       (rst),
    .req       (store_req),
    .draining  (draining),
    .code_valid(code_valid),
    .code_stall(code_stall),
    .code_data (code_data)
  );

endmodule

### tb/tb_binary_arithmetic_encoder.sv
// Self-checking testbench for binary_arithmetic_encoder: a directed request table, then
// random coding sequences; code bytes are checked against an interval coder predictor, or
// against the table for fixed rows. Depends on bae_pkg and the encoder RTL only.
module tb_binary_arithmetic_encoder;
  import bae_pkg::*;

  localparam int unsigned PW = PRECISION_BITS_DEF;
  localparam longint unsigned FULL_MASK = (64'd1 << PW) - 1;
  localparam longint unsigned TOP_BIT = 64'd1 << (PW - 1);
  localparam longint unsigned QUARTER = 64'd1 << (PW - 2);
  localparam longint unsigned FREQ_MASK = (64'd1 << FREQ_BITS_DEF) - 1;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int N_DIRECTED = 22;
  localparam int RANDOM_REQUESTS = 410;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    bae_cmd_t   cmd;
    logic       fixed;
    logic       has_code;
    logic [7:0] code_byte;
  } stim_row_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic      clk = 1'b0;
  logic      rst;
  logic      cmd_valid;
  logic      cmd_stall;
  bae_cmd_t  cmd_data;
  logic      code_valid;
  logic      code_stall;
  bae_code_t code_data;

  logic [PW-1:0]               code_low;
  logic [PW-1:0]               code_high;
  logic [PENDING_BITS_DEF-1:0] pending_bits;
  logic [7:0]                  shift_reg;
  logic [2:0]                  shift_fill;
  logic                        overflow_flag;

  logic [7:0] fresh_bytes[$];
  bae_code_t  expected_codes[$];
  bae_code_t  want;
  stim_row_t  directed_rows[N_DIRECTED];

  int          error_count = 0;
  int          cycle_count = 0;
  int          requests_sent = 0;
  int          burst_left = 0;
  int          stall_hold = 0;
  stall_mode_t stall_mode = STALL_NONE;

  binary_arithmetic_encoder dut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd_data(cmd_data),
    .code_valid(code_valid),
    .code_stall(code_stall),
    .code_data(code_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void restart_coder();
    code_low = '0;
    code_high = '1;
    pending_bits = '0;
    shift_reg = '0;
    shift_fill = '0;
    overflow_flag = 1'b0;
  endfunction

  function automatic void put_code_bit(input logic b);
    shift_reg = {b, shift_reg[7:1]};
    shift_fill = shift_fill + 3'd1;
    if (shift_fill == 3'd0 && fresh_bytes.size() < MAX_RESULTS) fresh_bytes.push_back(shift_reg);
  endfunction

  function automatic void put_with_pending(input logic b);
    put_code_bit(b);
    while (pending_bits != 0) begin
      pending_bits = pending_bits - 1'b1;
      put_code_bit(~b);
    end
  endfunction

  function automatic void count_underflow();
    if (&pending_bits) overflow_flag = 1'b1;
    else pending_bits = pending_bits + 1'b1;
  endfunction

  function automatic void encode_symbol(input logic sym, input longint unsigned fz,
                                        input longint unsigned ft);
    longint unsigned lo, hi, span, len;
    logic settled, middle, b, done;
    done = 1'b0;
    lo = code_low;
    hi = code_high;
    fz = fz & FREQ_MASK;
    ft = ft & FREQ_MASK;
    span = hi - lo + 1;
    len = (ft == 0) ? 64'hFFFF_FFFF_FFFF_FFFF : (span * fz) / ft;
    if (len > span - 1) len = span - 1;
    if (len < 1) len = 1;
    if (!sym) hi = (lo + len - 1) & FULL_MASK;
    else lo = (lo + len) & FULL_MASK;
    while (!done) begin
      settled = (lo & TOP_BIT) == (hi & TOP_BIT);
      middle = lo >= QUARTER && hi < TOP_BIT + QUARTER;
      if (!settled && !middle) begin
        done = 1'b1;
      end else begin
        if (settled) begin
          b = (lo & TOP_BIT) != 0;
          lo = (lo << 1) & FULL_MASK;
          hi = ((hi << 1) | 1) & FULL_MASK;
          put_with_pending(b);
        end
        if (lo >= QUARTER && hi < TOP_BIT + QUARTER) begin
          lo = ((lo << 1) & FULL_MASK) ^ TOP_BIT;
          hi = (((hi << 1) | 1) & FULL_MASK) ^ TOP_BIT;
          count_underflow();
        end
      end
    end
    code_low = lo[PW-1:0];
    code_high = hi[PW-1:0];
  endfunction

  function automatic void flush_code();
    logic b;
    b = code_low >= QUARTER;
    count_underflow();
    put_with_pending(b);
    if (shift_fill != 0) shift_reg = shift_reg >> (8 - shift_fill);
    if (fresh_bytes.size() < MAX_RESULTS) fresh_bytes.push_back(shift_reg);
    shift_fill = '0;
  endfunction

  function automatic void predict_codes(input bae_cmd_t c);
    fresh_bytes.delete();
    case (c.func)
      FUNC_ENCODE: encode_symbol(c.bit_value, c.freq_zero, c.freq_total);
      FUNC_FLUSH: flush_code();
      FUNC_RESTART: restart_coder();
      default: ;
    endcase
  endfunction

  function automatic bae_cmd_t make_cmd(input logic [1:0] func, input logic sym,
                                        input logic [15:0] fz, input logic [15:0] ft);
    bae_cmd_t c;
    c.func = func;
    c.bit_value = sym;
    c.freq_zero = fz;
    c.freq_total = ft;
    return c;
  endfunction

  function automatic stim_row_t stim_row(input logic [1:0] func, input logic sym,
                                         input logic [15:0] fz, input logic [15:0] ft,
                                         input logic fixed, input logic has_code,
                                         input logic [7:0] code_byte);
    stim_row_t r;
    r.cmd = make_cmd(func, sym, fz, ft);
    r.fixed = fixed;
    r.has_code = has_code;
    r.code_byte = code_byte;
    return r;
  endfunction

  function automatic bae_cmd_t random_symbol_cmd();
    int unsigned pick, total, zero;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      total = $urandom_range(2, 65535);
      zero = $urandom_range(1, total - 1);
    end else if (pick < 65) begin
      total = $urandom_range(2, 16);
      zero = $urandom_range(1, total - 1);
    end else if (pick < 80) begin
      total = $urandom_range(2, 65535);
      zero = $urandom_range(0, 1) ? 1 : total - 1;
    end else if (pick < 90) begin
      total = $urandom_range(0, 65535);
      zero = $urandom_range(total, 65535);
    end else begin
      total = $urandom & 16'hFFFF;
      zero = $urandom & 16'hFFFF;
    end
    return make_cmd(FUNC_ENCODE, 1'($urandom_range(0, 1)), 16'(zero), 16'(total));
  endfunction

  task automatic report_mismatch(input string what);
    if (error_count < 40) $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  task automatic send_request(input bae_cmd_t c, input logic fixed, input logic has_code,
                              input logic [7:0] code_byte);
    bae_code_t code;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        cmd_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    cmd_valid <= 1'b1;
    cmd_data <= c;
    do @(posedge clk); while (cmd_stall);
    predict_codes(c);
    if (c.func != FUNC_UNUSED) requests_sent++;
    if (fixed) begin
      if (has_code) begin
        code.out_byte = code_byte;
        code.last = 1'b1;
        code.pending_overflow = 1'b0;
        expected_codes.push_back(code);
      end
    end else begin
      foreach (fresh_bytes[i]) begin
        code.out_byte = fresh_bytes[i];
        code.last = (i == fresh_bytes.size() - 1);
        code.pending_overflow = overflow_flag;
        expected_codes.push_back(code);
      end
    end
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (!rst && code_valid && !code_stall) begin
      if (expected_codes.size() == 0) begin
        report_mismatch($sformatf("unexpected code byte %02h", code_data.out_byte));
      end else begin
        want = expected_codes.pop_front();
        if (code_data.out_byte !== want.out_byte)
          report_mismatch($sformatf("out_byte %02h, expected %02h",
                                    code_data.out_byte, want.out_byte));
        if (code_data.last !== want.last)
          report_mismatch($sformatf("last %b, expected %b", code_data.last, want.last));
        if (code_data.pending_overflow !== want.pending_overflow)
          report_mismatch($sformatf("pending_overflow %b, expected %b",
                                    code_data.pending_overflow, want.pending_overflow));
      end
    end
    if (stall_hold == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_hold = $urandom_range(20, 200);
    end else begin
      stall_hold--;
    end
    case (stall_mode)
      STALL_NONE: code_stall <= 1'b0;
      STALL_RANDOM: code_stall <= 1'($urandom_range(0, 1));
      STALL_HEAVY: code_stall <= ($urandom_range(0, 3) != 0);
      default: code_stall <= (cycle_count % 3 == 0);
    endcase
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    int kind, n, k;
    rst = 1'b1;
    cmd_valid = 1'b0;
    cmd_data = '0;
    code_stall = 1'b0;
    restart_coder();

    directed_rows[0]  = stim_row(FUNC_FLUSH, 1'b0, 16'h0000, 16'h0000, 1'b1, 1'b1, 8'h02);
    directed_rows[1]  = stim_row(FUNC_UNUSED, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 8'h00);
    directed_rows[2]  = stim_row(FUNC_RESTART, 1'b0, 16'h0000, 16'h0000, 1'b1, 1'b0, 8'h00);
    directed_rows[3]  = stim_row(FUNC_ENCODE, 1'b0, 16'h0001, 16'hFFFF, 1'b0, 1'b0, 8'h00);
    directed_rows[4]  = stim_row(FUNC_ENCODE, 1'b1, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 8'h00);
    directed_rows[5]  = stim_row(FUNC_ENCODE, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 8'h00);
    directed_rows[6]  = stim_row(FUNC_ENCODE, 1'b1, 16'hFFFF, 16'h0002, 1'b0, 1'b0, 8'h00);
    directed_rows[7]  = stim_row(FUNC_ENCODE, 1'b0, 16'h0001, 16'h0002, 1'b0, 1'b0, 8'h00);
    directed_rows[8]  = stim_row(FUNC_ENCODE, 1'b1, 16'h0001, 16'h0002, 1'b0, 1'b0, 8'h00);
    directed_rows[9]  = stim_row(FUNC_ENCODE, 1'b1, 16'h0000, 16'h0001, 1'b0, 1'b0, 8'h00);
    directed_rows[10] = stim_row(FUNC_ENCODE, 1'b0, 16'hAAAA, 16'h5555, 1'b0, 1'b0, 8'h00);
    directed_rows[11] = stim_row(FUNC_ENCODE, 1'b1, 16'h5555, 16'hAAAA, 1'b0, 1'b0, 8'h00);
    directed_rows[12] = stim_row(FUNC_FLUSH, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 8'h00);
    directed_rows[13] = stim_row(FUNC_FLUSH, 1'b1, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 8'h00);
    directed_rows[14] = stim_row(FUNC_RESTART, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 8'h00);
    directed_rows[15] = stim_row(FUNC_FLUSH, 1'b0, 16'h0000, 16'h0000, 1'b1, 1'b1, 8'h02);
    directed_rows[16] = stim_row(FUNC_RESTART, 1'b0, 16'h0000, 16'h0000, 1'b1, 1'b0, 8'h00);
    directed_rows[17] = stim_row(FUNC_ENCODE, 1'b1, 16'h7FFF, 16'hFFFF, 1'b0, 1'b0, 8'h00);
    directed_rows[18] = stim_row(FUNC_ENCODE, 1'b0, 16'h0002, 16'h8001, 1'b0, 1'b0, 8'h00);
    directed_rows[19] = stim_row(FUNC_FLUSH, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 8'h00);
    directed_rows[20] = stim_row(FUNC_UNUSED, 1'b0, 16'h0000, 16'h0000, 1'b1, 1'b0, 8'h00);
    directed_rows[21] = stim_row(FUNC_FLUSH, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 8'h00);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_request(directed_rows[i].cmd, directed_rows[i].fixed, directed_rows[i].has_code,
                   directed_rows[i].code_byte);

    requests_sent = 0;
    while (requests_sent < RANDOM_REQUESTS) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        if ($urandom_range(0, 4) != 0)
          send_request(make_cmd(FUNC_RESTART, 1'($urandom_range(0, 1)), 16'($urandom),
                                16'($urandom)), 1'b0, 1'b0, 8'h00);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(31, 80) : $urandom_range(1, 20);
        repeat (n) send_request(random_symbol_cmd(), 1'b0, 1'b0, 8'h00);
        if ($urandom_range(0, 6) != 0)
          send_request(make_cmd(FUNC_FLUSH, 1'($urandom_range(0, 1)), 16'($urandom),
                                16'($urandom)), 1'b0, 1'b0, 8'h00);
      end else if (kind < 82) begin
        // steer the interval tight around the midpoint to pile up pending bits
        k = $urandom_range(0, 1) ? $urandom_range(17, 20) : $urandom_range(1, 16);
        send_request(make_cmd(FUNC_RESTART, 1'b0, 16'h0000, 16'h0000), 1'b0, 1'b0, 8'h00);
        repeat (k) begin
          send_request(make_cmd(FUNC_ENCODE, 1'b1, 16'h7FFF, 16'hFFFF), 1'b0, 1'b0, 8'h00);
          send_request(make_cmd(FUNC_ENCODE, 1'b0, 16'h0002, 16'h8001), 1'b0, 1'b0, 8'h00);
        end
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 6)) send_request(random_symbol_cmd(), 1'b0, 1'b0, 8'h00);
        send_request(make_cmd(FUNC_FLUSH, 1'b0, 16'h0000, 16'h0000), 1'b0, 1'b0, 8'h00);
      end else begin
        send_request(make_cmd(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                              16'($urandom), 16'($urandom)), 1'b0, 1'b0, 8'h00);
      end
    end
    cmd_valid <= 1'b0;

    while (expected_codes.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
